// File: hdl/lkv_pkg.sv
// Shared constants and types for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 31;
    localparam int CAP_W       = 5;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [CAP_W-1:0]      CAP_RESET    = 5'd16;
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Recency update request from the controller to the rank tracker.
    typedef struct packed {
        logic touch;
        logic insert;
    } lkv_upd_t;

endpackage

`default_nettype wire

// File: hdl/lkv_rank.sv
// Valid bits, recency ranks and occupancy of the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

module lkv_rank
    import lkv_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int OCC_W  = $clog2(ENTRIES + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lkv_upd_t         upd,
    input  wire logic [IDX_W-1:0] upd_slot,
    input  wire logic [IDX_W-1:0] upd_rank,
    input  wire logic [OCC_W-1:0] evict_cnt,
    input  wire logic [IDX_W-1:0] rd_idx,
    output logic                  rd_valid,
    output logic      [IDX_W-1:0] rd_rank,
    output logic      [OCC_W-1:0] occupancy
);

    logic             valid_reg [ENTRIES];
    logic             valid_next[ENTRIES];
    logic [IDX_W-1:0] rank_reg  [ENTRIES];
    logic [IDX_W-1:0] rank_next [ENTRIES];
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign rd_valid  = valid_reg[rd_idx];
    assign rd_rank   = rank_reg[rd_idx];
    assign occupancy = occ_reg;

    always_comb begin
        occ_next = occ_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (upd.touch) begin
                if (valid_reg[i] && rank_reg[i] > upd_rank) begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
                if (upd_slot == IDX_W'(i)) begin
                    rank_next[i] = IDX_W'(occ_reg - 1'b1);
                end
            end else if (upd.insert) begin
                // batch eviction: every entry ranked below the count goes
                if (valid_reg[i]) begin
                    if (OCC_W'(rank_reg[i]) < evict_cnt) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end else begin
                        rank_next[i] = IDX_W'(OCC_W'(rank_reg[i]) - evict_cnt);
                    end
                end
                if (upd_slot == IDX_W'(i)) begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = IDX_W'(occ_reg - evict_cnt);
                end
            end
        end
        if (upd.insert) begin
            occ_next = occ_reg - evict_cnt + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end else begin
            occ_reg <= occ_next;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: APB register, key scan and result stage.
// A new request is accepted only in idle, after the previous result is issued. The key
// scan reads the single read port of the key/value memory, one entry per cycle.
// Reset: store empty, capacity 16; memory contents are not cleared and need no
// clearing pass, since only entries marked valid are ever compared.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic      [APB_DATA_W-1:0]   prdata,
    output logic                         pready,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_command,
    input  wire logic signed [KEY_W-1:0] s_key,
    input  wire logic        [VAL_W-1:0] s_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_found,
    output logic             [VAL_W-1:0] m_read_value
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int MEM_W = KEY_W + VAL_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0] cap_eff;
    logic [OCC_W-1:0] occupancy;
    logic [OCC_W-1:0] evict_cnt;

    // request capture
    logic             cmd_reg,       cmd_next;
    logic [KEY_W-1:0] key_reg,       key_next;
    logic [VAL_W-1:0] value_reg,     value_next;
    logic [OCC_W-1:0] evict_cnt_reg, evict_cnt_next;

    // scan
    logic [IDX_W-1:0] scan_idx_reg,  scan_idx_next;
    logic             cmp_vld_reg,   cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg,   cmp_idx_next;
    logic             hit_reg,       hit_next;
    logic [IDX_W-1:0] hit_slot_reg,  hit_slot_next;
    logic [IDX_W-1:0] hit_rank_reg,  hit_rank_next;
    logic [VAL_W-1:0] hit_value_reg, hit_value_next;
    logic             free_reg,      free_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;

    // result
    logic             m_valid_reg,   m_valid_next;
    logic             found_reg,     found_next;
    logic [VAL_W-1:0] rvalue_reg,    rvalue_next;

    // key/value memory
    logic [MEM_W-1:0] mem [ENTRIES];
    logic [MEM_W-1:0] mem_q_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    logic             rd_valid;
    logic [IDX_W-1:0] rd_rank;
    logic             fire;
    logic             put_on;
    logic             cfg_we;
    lkv_upd_t         upd;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
    assign prdata  = (paddr == ADDR_CAPACITY) ? APB_DATA_W'(cap_reg) : '0;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_found      = found_reg;
    assign m_read_value = rvalue_reg;

    assign cap_eff   = (int'(cap_reg) > ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(cap_reg);
    assign evict_cnt = (cap_eff != '0 && occupancy >= cap_eff)
                       ? OCC_W'(occupancy - cap_eff + 1'b1) : '0;

    assign fire   = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
    assign put_on = (cmd_reg == CMD_PUT) && (cap_eff != '0);

    assign upd.touch  = fire && hit_reg && ((cmd_reg == CMD_GET) || put_on);
    assign upd.insert = fire && put_on && !hit_reg;
    assign mem_we     = fire && put_on;
    assign mem_waddr  = hit_reg ? hit_slot_reg : free_slot_reg;

    lkv_rank #(
        .ENTRIES   (ENTRIES)
    ) u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (upd),
        .upd_slot  (mem_waddr),
        .upd_rank  (hit_rank_reg),
        .evict_cnt (evict_cnt_reg),
        .rd_idx    (cmp_idx_reg),
        .rd_valid  (rd_valid),
        .rd_rank   (rd_rank),
        .occupancy (occupancy)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= {key_reg, value_reg};
        end
        mem_q_reg <= mem[scan_idx_reg];
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        evict_cnt_next = evict_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_rank_next  = hit_rank_reg;
        hit_value_next = hit_value_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        found_next     = found_reg;
        rvalue_next    = rvalue_reg;

        // compare the entry read in the previous cycle
        if (cmp_vld_reg) begin
            if (!hit_reg && rd_valid && mem_q_reg[MEM_W-1:VAL_W] == key_reg) begin
                hit_next       = 1'b1;
                hit_slot_next  = cmp_idx_reg;
                hit_rank_next  = rd_rank;
                hit_value_next = mem_q_reg[VAL_W-1:0];
            end
            if (!free_reg && (!rd_valid || OCC_W'(rd_rank) < evict_cnt_reg)) begin
                free_next      = 1'b1;
                free_slot_next = cmp_idx_reg;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next       = s_command;
                    key_next       = s_key;
                    value_next     = s_value;
                    evict_cnt_next = evict_cnt;
                    scan_idx_next  = '0;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (scan_idx_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_LAST;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_LAST: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (fire) begin
                    m_valid_next = 1'b1;
                    found_next   = (cmd_reg == CMD_GET) && hit_reg;
                    rvalue_next  = ((cmd_reg == CMD_GET) && hit_reg) ? hit_value_reg : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            cap_reg     <= CAP_RESET;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        evict_cnt_reg <= evict_cnt_next;
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        hit_rank_reg  <= hit_rank_next;
        hit_value_reg <= hit_value_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        found_reg     <= found_next;
        rvalue_reg    <= rvalue_next;
    end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for lru_key_value_cache: get/put traffic checked against a cache model.
`timescale 1ns / 1ps

module tb_top;
    import lkv_pkg::*;

    localparam int          RANK_W        = $clog2(DEF_ENTRIES);
    localparam int          POOL_SIZE     = 24;
    localparam int          NUM_PHASES    = 10;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
    } cache_reply_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    psel      = 1'b0;
    logic                    penable   = 1'b0;
    logic                    pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr     = '0;
    logic [APB_DATA_W-1:0]   pwdata    = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic                    s_command = CMD_GET;
    logic signed [KEY_W-1:0] s_key     = '0;
    logic        [VAL_W-1:0] s_value   = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic                    m_found;
    logic        [VAL_W-1:0] m_read_value;

    // Cache model state
    logic signed [KEY_W-1:0]  model_key   [DEF_ENTRIES];
    logic        [VAL_W-1:0]  model_value [DEF_ENTRIES];
    logic                     model_live  [DEF_ENTRIES];
    logic        [RANK_W-1:0] model_rank  [DEF_ENTRIES];
    logic        [CAP_W-1:0]  model_count;
    logic        [CAP_W-1:0]  model_capacity;

    cache_reply_t            pending_replies[$];
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
    int unsigned             error_count     = 0;
    int unsigned             cycle_count     = 0;
    int unsigned             burst_left      = 0;
    bit                      gaps_on         = 1'b1;
    int unsigned             holds_requested = 0;
    int unsigned             holds_granted   = 0;

    lru_key_value_cache dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_read_value (m_read_value)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void clear_model();
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            model_key[i]   = '0;
            model_value[i] = '0;
            model_live[i]  = 1'b0;
            model_rank[i]  = '0;
        end
        model_count    = '0;
        model_capacity = CAP_RESET;
    endfunction

    function automatic int find_key(logic signed [KEY_W-1:0] key);
        int slot;
        slot = DEF_ENTRIES;
        for (int i = DEF_ENTRIES - 1; i >= 0; i--) begin
            if (model_live[i] && model_key[i] == key) begin
                slot = i;
            end
        end
        return slot;
    endfunction

    function automatic void make_most_recent(int slot);
        logic [RANK_W-1:0] old_rank;
        old_rank = model_rank[slot];
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (model_live[i] && model_rank[i] > old_rank) begin
                model_rank[i] = model_rank[i] - 1'b1;
            end
        end
        model_rank[slot] = RANK_W'(model_count - 1'b1);
    endfunction

    function automatic void evict_least_recent();
        int victim;
        victim = DEF_ENTRIES;
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (model_live[i] && model_rank[i] == '0) begin
                victim = i;
            end
        end
        if (victim < DEF_ENTRIES) begin
            model_live[victim] = 1'b0;
            model_rank[victim] = '0;
            for (int i = 0; i < DEF_ENTRIES; i++) begin
                if (model_live[i] && model_rank[i] != '0) begin
                    model_rank[i] = model_rank[i] - 1'b1;
                end
            end
            model_count = model_count - 1'b1;
        end
    endfunction

    function automatic cache_reply_t predict_reply(logic cmd, logic signed [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] val);
        cache_reply_t     reply;
        logic [CAP_W-1:0] limit;
        int               slot;
        logic             placed;
        reply.found      = 1'b0;
        reply.read_value = '0;
        limit = (model_capacity > DEF_ENTRIES) ? CAP_W'(DEF_ENTRIES) : model_capacity;
        slot  = find_key(key);
        if (cmd == CMD_GET) begin
            if (slot < DEF_ENTRIES) begin
                reply.found      = 1'b1;
                reply.read_value = model_value[slot];
                make_most_recent(slot);
            end
        end else if (limit != '0) begin
            if (slot < DEF_ENTRIES) begin
                model_value[slot] = val;
                make_most_recent(slot);
            end else begin
                while (model_count >= limit && model_count != '0) begin
                    evict_least_recent();
                end
                placed = 1'b0;
                for (int i = 0; i < DEF_ENTRIES; i++) begin
                    if (!placed && !model_live[i]) begin
                        model_live[i]  = 1'b1;
                        model_key[i]   = key;
                        model_value[i] = val;
                        model_rank[i]  = RANK_W'(model_count);
                        model_count    = model_count + 1'b1;
                        placed         = 1'b1;
                    end
                end
            end
        end
        return reply;
    endfunction

    function automatic logic signed [KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 9))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_ONES;
            3: return '0;
            4, 5: return key_pool[$urandom_range(0, POOL_SIZE-1)] ^
                         (KEY_W'(1) << $urandom_range(0, KEY_W-1));
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin : reply_checker
        cache_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result: found=%0b read_value=0x%0h", m_found, m_read_value);
                error_count++;
            end else begin
                want = pending_replies[0];
                pending_replies.delete(0);
                if (m_found !== want.found) begin
                    $error("found mismatch: expected %0b, actual %0b", want.found, m_found);
                    error_count++;
                end
                if (m_read_value !== want.read_value) begin
                    $error("read_value mismatch: expected 0x%0h, actual 0x%0h",
                           want.read_value, m_read_value);
                    error_count++;
                end
            end
        end
    end

    initial begin : result_sink
        int unsigned mode;
        int unsigned span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(posedge aclk);
                if (holds_granted != holds_requested) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    holds_granted++;
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    task automatic send_request(input logic cmd, input logic signed [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        s_value   <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_replies.push_back(predict_reply(cmd, key, val));
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic wait_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [APB_DATA_W-1:0] readback;
        apb_transfer(1'b1, ADDR_CAPACITY, APB_DATA_W'(cap), readback);
        model_capacity = cap;
        apb_transfer(1'b0, ADDR_CAPACITY, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (readback[CAP_W-1:0] !== cap) begin
            $error("capacity mismatch: expected %0d, actual %0d", cap, readback[CAP_W-1:0]);
            error_count++;
        end
    endtask

    task automatic test_empty_misses();
        send_request(CMD_GET, KEY_MIN, VAL_MAX);
        send_request(CMD_GET, KEY_ONES, '0);
        wait_replies();
    endtask

    task automatic test_eviction_order();
        set_capacity(5'd3);
        send_request(CMD_PUT, KEY_MIN, '0);
        send_request(CMD_PUT, KEY_MAX, VAL_MAX);
        send_request(CMD_PUT, '0, 31'd1);
        send_request(CMD_GET, KEY_MIN, '0);
        send_request(CMD_GET, KEY_MIN ^ 32'd1, '0);
        send_request(CMD_PUT, KEY_MAX, 31'd5);
        // store full: the new key pushes out the least recently used entry
        send_request(CMD_PUT, KEY_ONES, 31'h2AAA_AAAA);
        send_request(CMD_GET, '0, VAL_MAX);
        send_request(CMD_GET, KEY_MAX, '0);
        wait_replies();
    endtask

    task automatic test_capacity_zero();
        set_capacity(5'd0);
        send_request(CMD_PUT, 32'h1234_5678, 31'h5555_5555);
        send_request(CMD_GET, 32'h1234_5678, '0);
        send_request(CMD_GET, KEY_MIN, '0);
        wait_replies();
    endtask

    task automatic test_capacity_shrink();
        set_capacity(5'd1);
        send_request(CMD_GET, KEY_MAX, '0);
        send_request(CMD_PUT, 32'h5555_5555, 31'h1234_5678);
        send_request(CMD_GET, KEY_MIN, '0);
        send_request(CMD_GET, 32'h5555_5555, '0);
        wait_replies();
    endtask

    task automatic test_capacity_saturation();
        set_capacity(5'd31);
        send_request(CMD_PUT, 32'hAAAA_AAAA, VAL_MAX);
        send_request(CMD_GET, 32'hAAAA_AAAA, '0);
        send_request(CMD_GET, 32'h5555_5555, '0);
        wait_replies();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        holds_requested++;
        for (int n = 0; n < 30; n++) begin
            send_request(n[0] ? CMD_GET : CMD_PUT, 32'h0000_0100 + n / 2, VAL_W'($urandom));
        end
        gaps_on = 1'b1;
        wait_replies();
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0]        phase_caps [NUM_PHASES];
        logic [CAP_W-1:0]        in_use;
        int                      span;
        int                      count;
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic        [VAL_W-1:0] val;
        phase_caps = '{5'd16, 5'd31, 5'd5, 5'd0, 5'd1, 5'd2, 5'd16, 5'd9, 5'd30, 5'd3};
        phase_caps[7] = CAP_W'($urandom_range(2, 15));
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = KEY_ONES;
        key_pool[3] = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_replies();
            set_capacity(phase_caps[p]);
            for (int i = 0; i < POOL_SIZE; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    key_pool[i] = fresh_key();
                end
            end
            in_use = (phase_caps[p] > DEF_ENTRIES) ? CAP_W'(DEF_ENTRIES) : phase_caps[p];
            span   = (in_use == '0) ? DEF_ENTRIES : int'(in_use) + $urandom_range(1, 8);
            span   = (span < 4) ? 4 : ((span > POOL_SIZE) ? POOL_SIZE : span);
            count  = (in_use == '0) ? 60 : 160;
            for (int n = 0; n < count; n++) begin
                cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
                key = ($urandom_range(0, 9) == 0) ? fresh_key()
                                                  : key_pool[$urandom_range(0, span - 1)];
                case ($urandom_range(0, 9))
                    0: val = '0;
                    1: val = VAL_MAX;
                    default: val = VAL_W'($urandom);
                endcase
                send_request(cmd, key, val);
            end
        end
        wait_replies();
    endtask

    initial begin
        clear_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_misses();
        test_eviction_order();
        test_capacity_zero();
        test_capacity_shrink();
        test_capacity_saturation();
        test_backpressure();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: lru_key_value_cache.f
hdl/lkv_pkg.sv
hdl/lkv_rank.sv
hdl/lru_key_value_cache.sv
dv/tb_top.sv
